// File: rtl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared types, codes and defaults of the heartbeat membership table.
// ----------------------------------------------------------------------------
`default_nettype none

package hmt_pkg;

  localparam int unsigned DefMaxMembers = 32;

  localparam int unsigned IdW       = 32;
  localparam int unsigned PortW     = 16;
  localparam int unsigned HbW       = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned ActionW   = 2;
  localparam int unsigned EventW    = 3;
  localparam int unsigned EntryCntW = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [TimeoutW-1:0] DefRemoveTimeout = TimeoutW'(20);

  // actions
  localparam logic [ActionW-1:0] ActReport  = 2'd0;
  localparam logic [ActionW-1:0] ActTick    = 2'd1;
  localparam logic [ActionW-1:0] ActAddSelf = 2'd2;
  localparam logic [ActionW-1:0] ActClear   = 2'd3;

  // result events
  localparam logic [EventW-1:0] EvAdded    = 3'd0;
  localparam logic [EventW-1:0] EvUpdated  = 3'd1;
  localparam logic [EventW-1:0] EvSeen     = 3'd2;
  localparam logic [EventW-1:0] EvRemoved  = 3'd3;
  localparam logic [EventW-1:0] EvFull     = 3'd4;
  localparam logic [EventW-1:0] EvTickDone = 3'd5;
  localparam logic [EventW-1:0] EvCleared  = 3'd6;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgSelfId   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSelfPort = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout  = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PortW-1:0] port;
    logic [HbW-1:0]   hb;
    logic [TimeW-1:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/hmt_entry_ram.sv
// ----------------------------------------------------------------------------
// hmt_entry_ram
// Member entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmt_entry_ram #(
  parameter int unsigned DEPTH = hmt_pkg::DefMaxMembers
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      hmt_pkg::entry_t          rdata_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire hmt_pkg::entry_t          wdata_i
);
  import hmt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/heartbeat_membership_table.sv
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Gossip membership table: member reports, ticks with timeout removal,
// add self and clear, over one entry RAM scanned slot by slot.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a clock edge with start_i high and busy_o low.
//   Results appear on the result ports for one cycle each, marked by
//   result_valid_o; last_o flags the final result of a command. The
//   receiver has no way to hold results off.
//   Commands (N = MAX_MEMBERS):
//     clear      : result in the cycle after the transfer, no busy time.
//     report/add : scan of up to N slots through the RAM read port; the
//                  result lands when the scan ends.
//     tick       : always scans all N slots, one removal result per aged
//                  entry other than self as it is found, then tick done.
//   The single read port of the entry RAM paces the scan at one slot per
//   cycle; a new command is taken in the cycle busy_o falls.
//   Reset empties the table (valid bits cleared), zeroes the own heartbeat
//   and loads the register defaults. No clearing pass is needed.
//   Configuration writes are taken at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_membership_table #(
  parameter int unsigned MAX_MEMBERS = hmt_pkg::DefMaxMembers
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [hmt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [hmt_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                              start_i,
  output      logic                              busy_o,
  input  wire logic [hmt_pkg::ActionW-1:0]       action_i,
  input  wire logic [hmt_pkg::IdW-1:0]           member_id_i,
  input  wire logic [hmt_pkg::PortW-1:0]         member_port_i,
  input  wire logic [hmt_pkg::HbW-1:0]           report_heartbeat_i,
  input  wire logic [hmt_pkg::TimeW-1:0]         current_time_i,
  input  wire logic                              list_end_i,
  output      logic                              result_valid_o,
  output      logic [hmt_pkg::EventW-1:0]        event_kind_o,
  output      logic [hmt_pkg::IdW-1:0]           out_id_o,
  output      logic [hmt_pkg::PortW-1:0]         out_port_o,
  output      logic [hmt_pkg::HbW-1:0]           own_heartbeat_out_o,
  output      logic [hmt_pkg::EntryCntW-1:0]     entry_count_o,
  output      logic                              list_end_out_o,
  output      logic                              last_o
);
  import hmt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_MEMBERS);
  localparam int unsigned CntW = $clog2(MAX_MEMBERS + 1);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(MAX_MEMBERS - 1);
  localparam logic [CntW-1:0] NumSlots = CntW'(MAX_MEMBERS);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [IdW-1:0]         self_id_q;
  logic [PortW-1:0]       self_port_q;
  logic [TimeoutW-1:0]    timeout_q;
  logic [HbW-1:0]         own_hb_q, own_hb_d;
  logic [MAX_MEMBERS-1:0] valid_q, valid_d;
  logic [EntryCntW-1:0]   count_q, count_d;

  logic [ActionW-1:0]     act_q, act_d;
  logic [IdW-1:0]         id_q, id_d;
  logic [PortW-1:0]       port_q, port_d;
  logic [HbW-1:0]         hb_q, hb_d;
  logic [TimeW-1:0]       now_q, now_d;
  logic                   le_q, le_d;

  logic [CntW-1:0]        rd_cnt_q, rd_cnt_d;
  logic                   rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]        rd_slot_q, rd_slot_d;
  logic                   free_found_q, free_found_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic                   self_done_q, self_done_d;

  logic                   out_vld_q, out_vld_d;
  logic [EventW-1:0]      out_kind_q, out_kind_d;
  logic [IdW-1:0]         out_id_q, out_id_d;
  logic [PortW-1:0]       out_port_q, out_port_d;
  logic [HbW-1:0]         out_hb_q, out_hb_d;
  logic [EntryCntW-1:0]   out_cnt_q, out_cnt_d;
  logic                   out_le_q, out_le_d;
  logic                   out_last_q, out_last_d;

  logic                   ram_re;
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  entry_t                 ram_wdata;
  entry_t                 ent;

  logic                   slot_vld;
  logic                   hit;
  logic                   self_hit;
  logic [TimeW:0]         age;
  logic                   aged;
  logic                   last_slot;

  hmt_entry_ram #(
    .DEPTH (MAX_MEMBERS)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IdxW-1:0]),
    .rdata_o (ent),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  assign slot_vld  = valid_q[rd_slot_q];
  assign hit       = slot_vld && (ent.id == id_q) && (ent.port == port_q);
  assign self_hit  = slot_vld && (ent.id == self_id_q) && (ent.port == self_port_q);
  assign age       = {1'b0, now_q} - {1'b0, ent.stamp};
  assign aged      = !age[TimeW] && (age[TimeW-1:0] > {{(TimeW-TimeoutW){1'b0}}, timeout_q});
  assign last_slot = (rd_slot_q == LastSlot);

  always_comb begin
    state_d      = state_q;
    own_hb_d     = own_hb_q;
    valid_d      = valid_q;
    count_d      = count_q;
    act_d        = act_q;
    id_d         = id_q;
    port_d       = port_q;
    hb_d         = hb_q;
    now_d        = now_q;
    le_d         = le_q;
    rd_cnt_d     = rd_cnt_q;
    rd_pend_d    = 1'b0;
    rd_slot_d    = rd_slot_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    self_done_d  = self_done_q;
    out_vld_d    = 1'b0;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_port_d   = out_port_q;
    out_le_d     = 1'b0;
    out_last_d   = 1'b1;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = rd_slot_q;
    ram_wdata    = '{id: id_q, port: port_q, hb: hb_q, stamp: now_q};

    case (state_q)
      StIdle: begin
        if (start_i) begin
          act_d        = action_i;
          now_d        = current_time_i;
          rd_cnt_d     = '0;
          free_found_d = 1'b0;
          self_done_d  = 1'b0;
          if (action_i == ActReport) begin
            id_d   = member_id_i;
            port_d = member_port_i;
            hb_d   = report_heartbeat_i;
            le_d   = list_end_i;
          end else begin
            id_d   = self_id_q;
            port_d = self_port_q;
            hb_d   = own_hb_q;
            le_d   = 1'b0;
          end
          case (action_i)
            ActReport, ActAddSelf: begin
              state_d = StScan;
            end
            ActTick: begin
              own_hb_d = own_hb_q + HbW'(1);
              state_d  = StScan;
            end
            default: begin
              valid_d    = '0;
              count_d    = '0;
              out_vld_d  = 1'b1;
              out_kind_d = EvCleared;
              out_id_d   = self_id_q;
              out_port_d = self_port_q;
            end
          endcase
        end
      end

      StScan: begin
        if (rd_cnt_q != NumSlots) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_slot_d = rd_cnt_q[IdxW-1:0];
          rd_cnt_d  = rd_cnt_q + CntW'(1);
        end
        if (rd_pend_q) begin
          if (act_q == ActTick) begin
            if (self_hit) begin
              if (!self_done_q) begin
                ram_we      = 1'b1;
                ram_wdata   = '{id: ent.id, port: ent.port, hb: own_hb_q, stamp: now_q};
                self_done_d = 1'b1;
              end
            end else if (slot_vld && aged) begin
              valid_d[rd_slot_q] = 1'b0;
              count_d    = count_q - EntryCntW'(1);
              out_vld_d  = 1'b1;
              out_kind_d = EvRemoved;
              out_id_d   = ent.id;
              out_port_d = ent.port;
              out_last_d = 1'b0;
            end
            if (last_slot) begin
              state_d   = StDone;
              rd_pend_d = 1'b0;
            end
          end else if (hit) begin
            out_vld_d  = 1'b1;
            out_id_d   = id_q;
            out_port_d = port_q;
            out_le_d   = le_q;
            state_d    = StIdle;
            rd_pend_d  = 1'b0;
            if (act_q == ActAddSelf || hb_q > ent.hb) begin
              ram_we     = 1'b1;
              out_kind_d = EvUpdated;
            end else begin
              out_kind_d = EvSeen;
            end
          end else begin
            if (!free_found_q && !slot_vld) begin
              free_found_d = 1'b1;
              free_idx_d   = rd_slot_q;
            end
            if (last_slot) begin
              out_vld_d  = 1'b1;
              out_id_d   = id_q;
              out_port_d = port_q;
              out_le_d   = le_q;
              state_d    = StIdle;
              rd_pend_d  = 1'b0;
              if (free_found_q || !slot_vld) begin
                ram_we     = 1'b1;
                ram_waddr  = free_found_q ? free_idx_q : rd_slot_q;
                valid_d[ram_waddr] = 1'b1;
                count_d    = count_q + EntryCntW'(1);
                out_kind_d = EvAdded;
              end else begin
                out_kind_d = EvFull;
              end
            end
          end
        end
      end

      StDone: begin
        out_vld_d  = 1'b1;
        out_kind_d = EvTickDone;
        out_id_d   = self_id_q;
        out_port_d = self_port_q;
        state_d    = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    out_hb_d  = own_hb_d;
    out_cnt_d = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      self_id_q    <= '0;
      self_port_q  <= '0;
      timeout_q    <= DefRemoveTimeout;
      own_hb_q     <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      rd_cnt_q     <= '0;
      rd_pend_q    <= 1'b0;
      free_found_q <= 1'b0;
      self_done_q  <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      own_hb_q     <= own_hb_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      rd_cnt_q     <= rd_cnt_d;
      rd_pend_q    <= rd_pend_d;
      free_found_q <= free_found_d;
      self_done_q  <= self_done_d;
      out_vld_q    <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSelfId:   self_id_q   <= cfg_wdata_i[IdW-1:0];
          CfgSelfPort: self_port_q <= cfg_wdata_i[PortW-1:0];
          CfgTimeout:  timeout_q   <= cfg_wdata_i[TimeoutW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    id_q       <= id_d;
    port_q     <= port_d;
    hb_q       <= hb_d;
    now_q      <= now_d;
    le_q       <= le_d;
    rd_slot_q  <= rd_slot_d;
    free_idx_q <= free_idx_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_port_q <= out_port_d;
    out_hb_q   <= out_hb_d;
    out_cnt_q  <= out_cnt_d;
    out_le_q   <= out_le_d;
    out_last_q <= out_last_d;
  end

  assign busy_o              = (state_q != StIdle);
  assign result_valid_o      = out_vld_q;
  assign event_kind_o        = out_kind_q;
  assign out_id_o            = out_id_q;
  assign out_port_o          = out_port_q;
  assign own_heartbeat_out_o = out_hb_q;
  assign entry_count_o       = out_cnt_q;
  assign list_end_out_o      = out_le_q;
  assign last_o              = out_last_q;

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (count_q == EntryCntW'($countones(valid_q))))
    else $error("entry count out of step with valid bits");

  a_removal_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == EvRemoved) |-> (busy_o && !out_last_q))
    else $error("removal result outside a tick scan");

  a_only_removal_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_last_q) |-> (out_kind_q == EvRemoved))
    else $error("non-final result that is not a removal");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == ActClear)
      |=> (out_vld_q && out_last_q && out_cnt_q == '0 && !busy_o))
    else $error("clear did not report an empty table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (count_q <= EntryCntW'(MAX_MEMBERS)))
    else $error("entry count beyond table size");
`endif

endmodule

`default_nettype wire
